// ===== rtl/core/dqp_pkg.sv =====
// Shared types and constants for the DNS question parser.
package dqp_pkg;

  // Parameter defaults.
  localparam int unsigned NameLimitDef   = 256;
  localparam int unsigned PacketBytesDef = 512;

  // Protocol constants.
  localparam int unsigned HeaderBytes = 12;
  localparam logic [7:0]  LabelMax    = 8'd63;
  localparam logic [15:0] TypeA       = 16'd1;
  localparam logic [15:0] TypeNs      = 16'd2;
  localparam logic [15:0] TypeAaaa    = 16'd28;
  localparam logic [15:0] ClassIn     = 16'd1;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned WordW  = 16;
  localparam int unsigned WireW  = 9;
  localparam int unsigned TextW  = 8;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [CodeW-1:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_LABEL_LONG = 3'd2,
    ST_NAME_LONG  = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_e;

  typedef enum logic [CodeW-1:0] {
    ACT_ROOT_NS    = 3'd0,
    ACT_LOCAL_A    = 3'd1,
    ACT_LOCAL_AAAA = 3'd2,
    ACT_NOT_FOUND  = 3'd3,
    ACT_IGNORE     = 3'd4
  } action_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] name_char;
    status_e          status;
    action_e          action;
    logic [WordW-1:0] query_type;
    logic [WordW-1:0] query_class;
    logic [WireW-1:0] wire_length;
    logic [TextW-1:0] text_length;
  } result_t;

endpackage

// ===== rtl/core/dqp_in_if.sv =====
// Packet byte channel of the DNS question parser.
interface dqp_in_if;
  import dqp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

// ===== rtl/core/dqp_res_if.sv =====
// Result channel of the DNS question parser.
interface dqp_res_if;
  import dqp_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] name_char;
  logic [CodeW-1:0] status;
  logic [CodeW-1:0] action;
  logic [WordW-1:0] query_type;
  logic [WordW-1:0] query_class;
  logic [WireW-1:0] wire_length;
  logic [TextW-1:0] text_length;

  modport source (output valid, output kind, output name_char, output status, output action,
                  output query_type, output query_class, output wire_length,
                  output text_length, input ready);
  modport sink   (input valid, input kind, input name_char, input status, input action,
                  input query_type, input query_class, input wire_length,
                  input text_length, output ready);
endinterface

// ===== rtl/core/dqp_parse.sv =====
// Per-byte parser state machine producing at most one result per accepted byte.
module dqp_parse #(
  parameter int unsigned NAME_LIMIT   = dqp_pkg::NameLimitDef,
  parameter int unsigned PACKET_BYTES = dqp_pkg::PacketBytesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [dqp_pkg::ByteW-1:0] packet_byte_i,
  input  logic                    end_of_packet_i,
  output logic                    res_valid_o,
  output dqp_pkg::result_t        res_o
);
  import dqp_pkg::*;

  localparam int unsigned PosW = $clog2(PACKET_BYTES + 1);
  localparam logic [47:0] LocalSuffix = ".local";

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_LABEL  = 2'd2,
    PH_TAIL   = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [5:0]       left_q, left_d;
  logic [TextW-1:0] tc_q, tc_d;
  logic [WireW-1:0] enc_q, enc_d;
  logic [47:0]      win_q, win_d;
  logic [31:0]      tac_q, tac_d;
  logic             fin_q, fin_d;

  logic             char_put;
  logic [ByteW-1:0] char_val;
  logic [9:0]       name_need;
  logic             is_local;
  logic [WordW-1:0] qtype;
  logic [WordW-1:0] qclass;

  // Case-folded comparison of the last six name characters with ".local".
  function automatic logic ends_local(input logic [47:0] win, input logic [TextW-1:0] cnt);
    logic       match;
    logic [7:0] c;
    match = (cnt >= TextW'(6));
    for (int i = 0; i < 6; i++) begin
      c = win[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c + 8'd32;
      end
      if (c != LocalSuffix[8*i +: 8]) begin
        match = 1'b0;
      end
    end
    return match;
  endfunction

  // Type and class as they stand once the current byte is shifted in.
  assign name_need = {2'b00, tc_q} + {2'b00, packet_byte_i} + 10'd1;
  assign is_local  = ends_local(win_q, tc_q);
  assign qtype     = tac_q[23:8];
  assign qclass    = {tac_q[7:0], packet_byte_i};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    left_d      = left_q;
    tc_d        = tc_q;
    enc_d       = enc_q;
    win_d       = win_q;
    tac_d       = tac_q;
    fin_d       = fin_q;
    char_put    = 1'b0;
    char_val    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (!fin_q && pos_q < PosW'(PACKET_BYTES)) begin
        pos_d = pos_q + PosW'(1);
        unique case (phase_q)
          PH_HEADER: begin
            if (pos_q >= PosW'(HeaderBytes - 1)) begin
              phase_d = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            enc_d = enc_q + WireW'(1);
            if (packet_byte_i == '0) begin
              if (tc_q == '0) begin
                char_put = 1'b1;
                char_val = 8'h2e;
              end
              phase_d = PH_TAIL;
              left_d  = '0;
            end else if (packet_byte_i > LabelMax) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_ERROR;
              res_o.status = ST_LABEL_LONG;
              fin_d        = 1'b1;
            end else if (name_need >= 10'(NAME_LIMIT)) begin
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_ERROR;
              res_o.status = ST_NAME_LONG;
              fin_d        = 1'b1;
            end else begin
              if (tc_q != '0) begin
                char_put = 1'b1;
                char_val = 8'h2e;
              end
              left_d  = packet_byte_i[5:0];
              phase_d = PH_LABEL;
            end
          end
          PH_LABEL: begin
            enc_d    = enc_q + WireW'(1);
            char_put = 1'b1;
            char_val = packet_byte_i;
            left_d   = left_q - 6'd1;
            if (left_q == 6'd1) begin
              phase_d = PH_LENGTH;
            end
          end
          PH_TAIL: begin
            tac_d  = {tac_q[23:0], packet_byte_i};
            left_d = left_q + 6'd1;
            if (left_q >= 6'd3) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_SUMMARY;
              res_o.query_type  = qtype;
              res_o.query_class = qclass;
              res_o.wire_length = enc_q;
              res_o.text_length = tc_q;
              if (qclass != ClassIn) begin
                res_o.action = ACT_IGNORE;
              end else if (tc_q == TextW'(1) && win_q[7:0] == 8'h2e &&
                           enc_q == WireW'(1) && qtype == TypeNs) begin
                res_o.action = ACT_ROOT_NS;
              end else if (is_local && qtype == TypeA) begin
                res_o.action = ACT_LOCAL_A;
              end else if (is_local && qtype == TypeAaaa) begin
                res_o.action = ACT_LOCAL_AAAA;
              end else begin
                res_o.action = ACT_NOT_FOUND;
              end
              fin_d = 1'b1;
            end
          end
          default: phase_d = PH_HEADER;
        endcase
      end

      if (char_put) begin
        win_d           = {win_q[39:0], char_val};
        tc_d            = tc_q + TextW'(1);
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_CHAR;
        res_o.name_char = char_val;
      end

      if (end_of_packet_i) begin
        if (!fin_d) begin
          res_valid_o  = 1'b1;
          res_o        = '0;
          res_o.kind   = KIND_ERROR;
          res_o.status = (phase_d == PH_HEADER) ? ST_SHORT : ST_TRUNCATED;
        end
        phase_d = PH_HEADER;
        pos_d   = '0;
        left_d  = '0;
        tc_d    = '0;
        enc_d   = '0;
        win_d   = '0;
        tac_d   = '0;
        fin_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      left_q  <= '0;
      tc_q    <= '0;
      enc_q   <= '0;
      win_q   <= '0;
      tac_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      tc_q    <= tc_d;
      enc_q   <= enc_d;
      win_q   <= win_d;
      tac_q   <= tac_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== rtl/core/dqp_res_fifo.sv =====
// Two-entry result buffer between the parser and the result channel.
module dqp_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dqp_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output dqp_pkg::result_t data_o
);
  import dqp_pkg::*;

  result_t    mem_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic       pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/dns_question_parser_top.sv =====
// Top level of the DNS question parser: byte-stream parser plus result buffer.
// Each byte's result, if any, is written to the result buffer at the edge that accepts the
// byte and shows on the result channel after that edge, behind any waiting results.
// Throughput: one byte per cycle while the buffer has room; each byte is a single step.
// A two-entry result buffer lets a byte be taken while an earlier result is still waiting.
// Reset (rst_ni low, asynchronous) returns the parser to header skip and empties the buffer.
module dns_question_parser_top #(
  parameter int unsigned NAME_LIMIT   = dqp_pkg::NameLimitDef,
  parameter int unsigned PACKET_BYTES = dqp_pkg::PacketBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqp_in_if.sink    pkt_i,
  dqp_res_if.source res_o
);
  import dqp_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    buf_full;

  // A byte transaction completes whenever the buffer has a free entry. Bytes that give
  // no result are accepted on the same terms, which keeps the input side simple.
  assign pkt_i.ready = !buf_full;
  assign step        = pkt_i.valid && pkt_i.ready;

  // The parser holds the whole per-packet state: phase, byte position, one counter
  // shared by label and tail bytes, the name counters, a finished flag, the last six
  // name characters for the ".local" test, and the collected type and class bytes.
  dqp_parse #(
    .NAME_LIMIT  (NAME_LIMIT),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .packet_byte_i  (pkt_i.packet_byte),
    .end_of_packet_i(pkt_i.end_of_packet),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Each result is registered in the buffer at the edge that accepts its byte.
  dqp_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step && res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .valid_o    (res_o.valid),
    .pop_i      (res_o.ready),
    .data_o     (head)
  );

  // Unpack the buffered result onto the result channel.
  assign res_o.kind        = head.kind;
  assign res_o.name_char   = head.name_char;
  assign res_o.status      = head.status;
  assign res_o.action      = head.action;
  assign res_o.query_type  = head.query_type;
  assign res_o.query_class = head.query_class;
  assign res_o.wire_length = head.wire_length;
  assign res_o.text_length = head.text_length;

endmodule

// ===== rtl/core/dqp_checker.sv =====
// Port-level assertions for the DNS question parser and their binding.
module dqp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [dqp_pkg::KindW-1:0] kind_i,
  input logic [dqp_pkg::ByteW-1:0] name_char_i,
  input logic [dqp_pkg::CodeW-1:0] status_i,
  input logic [dqp_pkg::CodeW-1:0] action_i,
  input logic [dqp_pkg::WireW-1:0] wire_length_i,
  input logic [dqp_pkg::TextW-1:0] text_length_i
);
  import dqp_pkg::*;

  // A waiting result holds its kind, character, status and wire length until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(kind_i) &&
      $stable(name_char_i) && $stable(status_i) && $stable(wire_length_i))
    else $error("result changed while stalled");

  // With nothing buffered the parser must be able to take a byte.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> in_ready_i)
    else $error("input stalled with an empty result buffer");

  // Character results carry no status, action or lengths.
  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == KIND_CHAR |->
      status_i == ST_OK && action_i == ACT_ROOT_NS && wire_length_i == '0 &&
      text_length_i == '0)
    else $error("character result with stray fields");

  // A summary always covers at least the terminator and one character.
  a_summary_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == KIND_SUMMARY |->
      status_i == ST_OK && wire_length_i != '0 && text_length_i != '0)
    else $error("malformed summary result");

  // Error results carry a real error code and no character.
  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == KIND_ERROR |->
      status_i != ST_OK && name_char_i == '0 &&
      (status_i == ST_SHORT || status_i == ST_LABEL_LONG ||
       status_i == ST_NAME_LONG || status_i == ST_TRUNCATED))
    else $error("error result without a valid code");

endmodule

bind dns_question_parser_top dqp_checker u_dqp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pkt_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .kind_i       (res_o.kind),
  .name_char_i  (res_o.name_char),
  .status_i     (res_o.status),
  .action_i     (res_o.action),
  .wire_length_i(res_o.wire_length),
  .text_length_i(res_o.text_length)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the DNS question parser: stimulus, prediction and checking.
module testbench;
  import dqp_pkg::*;

  localparam int unsigned NameLimit     = NameLimitDef;
  localparam int unsigned PacketBytes   = PacketBytesDef;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned ByteBudget    = 1500;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned TimeoutCycles = 400_000;

  localparam logic [7:0]  DotChar     = ".";
  localparam logic [39:0] LocalWord   = "local";
  localparam logic [47:0] LocalSuffix = ".local";

  // Where the parser stands within the current packet.
  typedef enum logic [1:0] {
    SKIP_HEADER,
    READ_LENGTH,
    READ_LABEL,
    READ_TAIL
  } walk_e;

  // Tracks one parser: it mirrors the per-packet state byte by byte, keeps the
  // results that are still owed, and matches them against what comes out.
  class question_tracker;
    result_t     owed[$];
    int unsigned failures;
    int unsigned kind_seen[3];
    int unsigned action_seen[5];
    int unsigned status_seen[5];

    walk_e       walk;
    int unsigned pos;
    logic [5:0]  body_left;
    logic [7:0]  text_cnt;
    logic [8:0]  wire_cnt;
    logic [47:0] recent_chars;
    logic [31:0] type_class;
    bit          done;

    function new();
      restart();
    endfunction

    function void restart();
      walk         = SKIP_HEADER;
      pos          = 0;
      body_left    = '0;
      text_cnt     = '0;
      wire_cnt     = '0;
      recent_chars = '0;
      type_class   = '0;
      done         = 1'b0;
    endfunction

    function result_t emit_char(logic [7:0] c);
      result_t r;
      r            = '0;
      r.kind       = KIND_CHAR;
      r.name_char  = c;
      recent_chars = {recent_chars[39:0], c};
      text_cnt     = text_cnt + 8'd1;
      return r;
    endfunction

    function result_t emit_fault(status_e code);
      result_t r;
      r        = '0;
      r.kind   = KIND_ERROR;
      r.status = code;
      done     = 1'b1;
      return r;
    endfunction

    // Called for every accepted input transaction.
    function void take_byte(logic [7:0] b, logic eop);
      result_t     r;
      bit          have;
      bit          is_local;
      logic [7:0]  c;
      logic [47:0] folded;
      logic [15:0] qtype;
      logic [15:0] qclass;
      have = 1'b0;
      r    = '0;
      if (!done && pos < PacketBytes) begin
        case (walk)
          SKIP_HEADER: begin
            if (pos + 1 >= HeaderBytes) walk = READ_LENGTH;
          end
          READ_LENGTH: begin
            wire_cnt = wire_cnt + 9'd1;
            if (b == 8'd0) begin
              if (text_cnt == 8'd0) begin
                r    = emit_char(DotChar);
                have = 1'b1;
              end
              walk      = READ_TAIL;
              body_left = '0;
            end else if (b > LabelMax) begin
              r    = emit_fault(ST_LABEL_LONG);
              have = 1'b1;
            end else if (int'(text_cnt) + int'(b) + 1 >= int'(NameLimit)) begin
              r    = emit_fault(ST_NAME_LONG);
              have = 1'b1;
            end else begin
              if (text_cnt != 8'd0) begin
                r    = emit_char(DotChar);
                have = 1'b1;
              end
              body_left = b[5:0];
              walk      = READ_LABEL;
            end
          end
          READ_LABEL: begin
            wire_cnt  = wire_cnt + 9'd1;
            r         = emit_char(b);
            have      = 1'b1;
            body_left = body_left - 6'd1;
            if (body_left == 6'd0) walk = READ_LENGTH;
          end
          default: begin
            type_class = {type_class[23:0], b};
            body_left  = body_left + 6'd1;
            if (body_left >= 6'd4) begin
              qtype  = type_class[31:16];
              qclass = type_class[15:0];
              // The suffix test folds upper-case ASCII letters before comparing.
              for (int i = 0; i < 6; i++) begin
                c = recent_chars[8*i +: 8];
                if (c >= "A" && c <= "Z") c = c + 8'd32;
                folded[8*i +: 8] = c;
              end
              is_local = (text_cnt >= 8'd6) && (folded == LocalSuffix);
              r        = '0;
              r.kind   = KIND_SUMMARY;
              if (qclass != ClassIn) r.action = ACT_IGNORE;
              else if (text_cnt == 8'd1 && recent_chars[7:0] == DotChar &&
                       wire_cnt == 9'd1 && qtype == TypeNs) r.action = ACT_ROOT_NS;
              else if (is_local && qtype == TypeA) r.action = ACT_LOCAL_A;
              else if (is_local && qtype == TypeAaaa) r.action = ACT_LOCAL_AAAA;
              else r.action = ACT_NOT_FOUND;
              r.query_type  = qtype;
              r.query_class = qclass;
              r.wire_length = wire_cnt;
              r.text_length = text_cnt;
              done          = 1'b1;
              have          = 1'b1;
            end
          end
        endcase
        pos++;
      end
      // The end mark closes the packet; an unfinished packet reports why.
      if (eop) begin
        if (!done) begin
          r    = emit_fault(walk == SKIP_HEADER ? ST_SHORT : ST_TRUNCATED);
          have = 1'b1;
        end
        restart();
      end
      if (have) owed.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    // Called for every accepted result transaction.
    function void match_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d char %0d status %0d",
                 $time, got.kind, got.name_char, got.status);
        failures++;
        return;
      end
      want = owed.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("name_char", want.name_char, got.name_char);
      compare_field("status", want.status, got.status);
      compare_field("action", want.action, got.action);
      compare_field("query_type", want.query_type, got.query_type);
      compare_field("query_class", want.query_class, got.query_class);
      compare_field("wire_length", want.wire_length, got.wire_length);
      compare_field("text_length", want.text_length, got.text_length);
      kind_seen[want.kind]++;
      if (want.kind == KIND_SUMMARY) action_seen[want.action]++;
      if (want.kind == KIND_ERROR) status_seen[want.status]++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dqp_in_if  pkt_if ();
  dqp_res_if res_if ();

  dns_question_parser_top #(
    .NAME_LIMIT  (NameLimit),
    .PACKET_BYTES(PacketBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt_if),
    .res_o (res_if)
  );

  question_tracker tracker;
  logic [7:0]      frame_q[$];
  int unsigned     burst_left;
  int unsigned     bytes_sent;
  int unsigned     packets_sent;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Generous hard stop in case the parser hangs or drops a result.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("dns_question_parser_top verification failed");
    $finish;
  end

  // Result side back-pressure. The receiver cycles through modes of random
  // length: always ready, randomly ready with a chance of three in four, and a
  // fixed duty pattern that is ready three eighths of the time.
  initial begin : result_backpressure
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase_cnt;
    mode      = 0;
    mode_left = 0;
    phase_cnt = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= ((phase_cnt % 8) < 3);
      endcase
    end
  end

  // Every result transaction is matched at the edge that accepts it. Values are
  // read in the active region, so they are the ones present before the edge.
  always @(posedge clk_i) begin : watch_results
    result_t seen;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = {res_if.kind, res_if.name_char, res_if.status, res_if.action,
              res_if.query_type, res_if.query_class, res_if.wire_length,
              res_if.text_length};
      tracker.match_result(seen);
    end
  end

  // Drives one byte and holds it until the parser takes it. The sender works in
  // bursts; when a burst runs out it drops valid for a short random gap. Now and
  // then a burst is long enough to give a stretch without idle cycles.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    if (burst_left == 0) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    pkt_if.valid         <= 1'b1;
    pkt_if.packet_byte   <= b;
    pkt_if.end_of_packet <= eop;
    @(posedge clk_i);
    while (!pkt_if.ready) @(posedge clk_i);
    tracker.take_byte(b, eop);
    bytes_sent++;
  endtask

  // Sends the assembled frame, with the end mark on its last byte.
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    packets_sent++;
  endtask

  // Name characters lean toward letters of both cases but include any byte,
  // zero bytes and dots among them.
  function automatic logic [7:0] label_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'($urandom_range(97, 122));
      3, 4:    return 8'($urandom_range(65, 90));
      5:       return ($urandom_range(0, 1) != 0) ? 8'h00 : DotChar;
      default: return 8'($urandom);
    endcase
  endfunction

  // Builds a query: random header, a question name, type and class. Most frames
  // are well formed so the parser gets through to the summary; some names end
  // in a mixed-case "local" label, some are the root, a few are long enough to
  // overflow the name buffer, and some frames are cut short or carry trailing bytes.
  task automatic compose_frame();
    int unsigned pick;
    int unsigned nlab;
    int unsigned len;
    int unsigned est;
    int unsigned cut;
    logic [7:0]  ch;
    logic [15:0] qtype;
    logic [15:0] qclass;
    frame_q.delete();
    repeat (HeaderBytes) frame_q.push_back(8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      // Big labels until one no longer fits the name buffer.
      est = 0;
      forever begin
        len = $urandom_range(40, 63);
        frame_q.push_back(8'(len));
        repeat (len) frame_q.push_back(label_char());
        if (est + len + 1 >= NameLimit) break;
        est = est + len + ((est > 0) ? 1 : 0);
      end
    end else begin
      if (pick >= 10) begin
        nlab = $urandom_range(0, 3);
        repeat (nlab) begin
          if ($urandom_range(0, 24) == 0) begin
            // A length byte past the label limit stops the parse at once.
            frame_q.push_back(8'($urandom_range(64, 255)));
          end else begin
            len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 10);
            frame_q.push_back(8'(len));
            repeat (len) frame_q.push_back(label_char());
          end
        end
        if (pick < 55) begin
          frame_q.push_back(8'd5);
          for (int i = 4; i >= 0; i--) begin
            ch = LocalWord[8*i +: 8];
            if ($urandom_range(0, 2) == 0) ch = ch - 8'd32;
            frame_q.push_back(ch);
          end
        end
      end
      frame_q.push_back(8'h00);
    end
    case ($urandom_range(0, 4))
      0:       qtype = TypeA;
      1:       qtype = TypeAaaa;
      2:       qtype = TypeNs;
      3:       qtype = ($urandom_range(0, 1) != 0) ? TypeA : TypeAaaa;
      default: qtype = 16'($urandom);
    endcase
    qclass = ($urandom_range(0, 4) != 0) ? ClassIn : 16'($urandom);
    frame_q.push_back(qtype[15:8]);
    frame_q.push_back(qtype[7:0]);
    frame_q.push_back(qclass[15:8]);
    frame_q.push_back(qclass[7:0]);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Cut the frame, often inside the header so the short case shows up.
      cut = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 14)
                                        : $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic wait_for_results();
    while (tracker.owed.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    tracker      = new();
    burst_left   = 0;
    bytes_sent   = 0;
    packets_sent = 0;
    rst_ni               = 1'b0;
    pkt_if.valid         <= 1'b0;
    pkt_if.packet_byte   <= '0;
    pkt_if.end_of_packet <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-byte packet that ends inside the header.
    frame_q = '{8'hff};
    send_frame();
    // Directed: root NS probe, header bytes at both extremes.
    frame_q = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                8'h00, 8'h00, 8'h02, 8'h00, 8'h01};
    send_frame();
    // Directed: the largest length byte, which is far over the label limit.
    frame_q = '{8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00,
                8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
    send_frame();

    // Random frames. Once, about half way, the sender holds off until every
    // owed result has been delivered, so the parser is seen to drain fully.
    while (bytes_sent < ByteBudget) begin
      if (bytes_sent >= ByteBudget / 2 && bytes_sent - frame_q.size() < ByteBudget / 2) begin
        pkt_if.valid <= 1'b0;
        @(posedge clk_i);
        wait_for_results();
        burst_left = 0;
      end
      compose_frame();
      send_frame();
    end

    pkt_if.valid <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d packets (%0d bytes): %0d name characters, %0d summaries, %0d errors.",
             packets_sent, bytes_sent, tracker.kind_seen[KIND_CHAR],
             tracker.kind_seen[KIND_SUMMARY], tracker.kind_seen[KIND_ERROR]);
    $display({"Actions root/A/AAAA/miss/ignore %0d/%0d/%0d/%0d/%0d; ",
              "errors short/label/name/trunc %0d/%0d/%0d/%0d."},
             tracker.action_seen[ACT_ROOT_NS], tracker.action_seen[ACT_LOCAL_A],
             tracker.action_seen[ACT_LOCAL_AAAA], tracker.action_seen[ACT_NOT_FOUND],
             tracker.action_seen[ACT_IGNORE], tracker.status_seen[ST_SHORT],
             tracker.status_seen[ST_LABEL_LONG], tracker.status_seen[ST_NAME_LONG],
             tracker.status_seen[ST_TRUNCATED]);
    if (tracker.failures == 0) begin
      $display("dns_question_parser_top verification clean");
    end else begin
      $display("dns_question_parser_top verification failed");
    end
    $finish;
  end

endmodule

// ===== dns_question_parser_top.f =====
rtl/core/dqp_pkg.sv
rtl/core/dqp_in_if.sv
rtl/core/dqp_res_if.sv
rtl/core/dqp_parse.sv
rtl/core/dqp_res_fifo.sv
rtl/core/dns_question_parser_top.sv
rtl/core/dqp_checker.sv
tb/sv/testbench.sv
